/* hdl/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the sprite line evaluator.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int unsigned SlotsPerLine = 8;
  localparam int unsigned TableEntries = 64;

  // counters hold their limit value, so one extra code is needed
  localparam int unsigned HitW   = $clog2(SlotsPerLine + 1);
  localparam int unsigned EntryW = $clog2(TableEntries + 1);

  localparam int unsigned LineW  = 8;
  localparam int unsigned RowW   = 5;
  localparam int unsigned SlotW  = 3;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [7:0] EndMarkY       = 8'd208;
  localparam logic [7:0] ActiveLinesRst = 8'd192;

  typedef enum logic [2:0] {
    REG_TALL   = 3'd0,
    REG_ZOOM   = 3'd1,
    REG_EXT    = 3'd2,
    REG_LIMIT  = 3'd3,
    REG_ACTIVE = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic       tall_sprites;
    logic       zoom_sprites;
    logic       extended_mode;
    logic       limit_enable;
    logic [7:0] active_lines;
  } cfg_t;

endpackage

/* hdl/sle_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sle_cfg_regs
// APB register bank holding the sprite evaluation mode bits.
// ----------------------------------------------------------------------------
module sle_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sle_pkg::AddrW-1:0]   paddr,
  input  logic [sle_pkg::DataW-1:0]   pwdata,
  output logic [sle_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output sle_pkg::cfg_t               cfg_o
);

  sle_pkg::cfg_t     cfg_q, cfg_d;
  sle_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = sle_pkg::reg_idx_e'(paddr[sle_pkg::AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        sle_pkg::REG_TALL:   cfg_d.tall_sprites  = pwdata[0];
        sle_pkg::REG_ZOOM:   cfg_d.zoom_sprites  = pwdata[0];
        sle_pkg::REG_EXT:    cfg_d.extended_mode = pwdata[0];
        sle_pkg::REG_LIMIT:  cfg_d.limit_enable  = pwdata[0];
        sle_pkg::REG_ACTIVE: cfg_d.active_lines  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sle_pkg::REG_TALL:   prdata = {31'd0, cfg_q.tall_sprites};
      sle_pkg::REG_ZOOM:   prdata = {31'd0, cfg_q.zoom_sprites};
      sle_pkg::REG_EXT:    prdata = {31'd0, cfg_q.extended_mode};
      sle_pkg::REG_LIMIT:  prdata = {31'd0, cfg_q.limit_enable};
      sle_pkg::REG_ACTIVE: prdata = {24'd0, cfg_q.active_lines};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tall_sprites  <= 1'b0;
      cfg_q.zoom_sprites  <= 1'b0;
      cfg_q.extended_mode <= 1'b0;
      cfg_q.limit_enable  <= 1'b1;
      cfg_q.active_lines  <= sle_pkg::ActiveLinesRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/sprite_line_evaluator.sv */
// ----------------------------------------------------------------------------
// sprite_line_evaluator
// Per-scanline sprite attribute evaluation: one table entry in, one result out.
// ----------------------------------------------------------------------------
// result: captured in the output register in the cycle after the input transaction
// throughput: one entry per cycle while the output is not stalled, set by the single output register stage
// input stalls only while a result is held and the downstream side is not ready
// reset: line state, sticky flags and output valid cleared; registers to defaults
module sprite_line_evaluator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input entries
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // line_number, entry_y, entry_x, entry_tile
  input  logic                        s_axis_tuser,  // line_start
  // results
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // slot, row_in_sprite, out_x, out_tile, overflow_flag, sprite_seen, scan_stopped, 5 zeros
  output logic [31:0]                 m_axis_tdata,
  output logic                        m_axis_tuser,  // accepted
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sle_pkg::AddrW-1:0]   paddr,
  input  logic [sle_pkg::DataW-1:0]   pwdata,
  output logic [sle_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  sle_pkg::cfg_t cfg;

  sle_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // line scan state
  logic [sle_pkg::HitW-1:0]   hit_q, hit_d, hit_cur;
  logic [sle_pkg::EntryW-1:0] ent_q, ent_d, ent_cur;
  logic                       stop_q, stop_d, stop_cur;
  logic                       ovf_q, ovf_d;
  logic                       seen_q, seen_d;

  // output register
  logic                       m_valid_q;
  logic                       acc_q, acc_d;
  logic [sle_pkg::SlotW-1:0]  slot_q, slot_d;
  logic [sle_pkg::RowW-1:0]   row_q, row_d;
  logic [7:0]                 x_q, x_d;
  logic [7:0]                 tile_q, tile_d;

  logic                       in_fire;
  logic [7:0]                 line_num, ent_y, ent_x, ent_tile;
  logic [7:0]                 y_eff, row;
  logic                       active, term, in_range, hit, full, acc;
  logic [sle_pkg::HitW+2:0]   hit_ext;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign line_num = s_axis_tdata[7:0];
  assign ent_y    = s_axis_tdata[15:8];
  assign ent_x    = s_axis_tdata[23:16];
  assign ent_tile = s_axis_tdata[31:24];

  always_comb begin
    // a line start clears the scan before this entry is evaluated
    hit_cur  = s_axis_tuser ? '0 : hit_q;
    ent_cur  = s_axis_tuser ? '0 : ent_q;
    stop_cur = s_axis_tuser ? 1'b0 : stop_q;

    active = !stop_cur && (ent_cur < sle_pkg::EntryW'(sle_pkg::TableEntries));
    term   = !cfg.extended_mode && (ent_y == sle_pkg::EndMarkY);
    y_eff  = ent_y | {7'd0, cfg.zoom_sprites};
    row    = line_num - y_eff;

    case ({cfg.tall_sprites, cfg.zoom_sprites})
      2'b11:   in_range = (row[7:5] == 3'd0);
      2'b10,
      2'b01:   in_range = (row[7:4] == 4'd0);
      default: in_range = (row[7:3] == 5'd0);
    endcase

    hit  = active && !term && in_range;
    full = (hit_cur >= sle_pkg::HitW'(sle_pkg::SlotsPerLine));
    acc  = hit && !full;

    hit_d  = acc ? hit_cur + 1'b1 : hit_cur;
    ent_d  = active ? ent_cur + 1'b1 : ent_cur;
    stop_d = stop_cur || (active && term) || (hit && full && cfg.limit_enable);
    ovf_d  = ovf_q || (hit && full && (line_num < cfg.active_lines));
    seen_d = seen_q || hit;

    hit_ext = {3'd0, hit_cur};
    acc_d   = acc;
    slot_d  = acc ? hit_ext[2:0] : '0;
    row_d   = acc ? row[4:0] : '0;
    x_d     = acc ? ent_x : '0;
    tile_d  = acc ? ent_tile : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q     <= '0;
      ent_q     <= '0;
      stop_q    <= 1'b0;
      ovf_q     <= 1'b0;
      seen_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        hit_q  <= hit_d;
        ent_q  <= ent_d;
        stop_q <= stop_d;
        ovf_q  <= ovf_d;
        seen_q <= seen_d;
      end
      if (in_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      acc_q  <= acc_d;
      slot_q <= slot_d;
      row_q  <= row_d;
      x_q    <= x_d;
      tile_q <= tile_d;
    end
  end

  // sticky and stop bits travel with the result of the entry that set them
  logic ovf_out_q, seen_out_q, stop_out_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ovf_out_q  <= ovf_d;
      seen_out_q <= seen_d;
      stop_out_q <= stop_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = acc_q;
  assign m_axis_tdata  = {5'd0, stop_out_q, seen_out_q, ovf_out_q,
                          tile_q, x_q, row_q, slot_q};

endmodule

/* tb/sle_scan_checker.sv */
// ----------------------------------------------------------------------------
// sle_scan_checker
// Watches the entry, result and register channels of the sprite line
// evaluator, predicts every result from the accepted entries and compares it
// field by field with what the block returns.
// ----------------------------------------------------------------------------
module sle_scan_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,
  input  logic                      s_axis_tuser,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [31:0]               m_axis_tdata,
  input  logic                      m_axis_tuser,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sle_pkg::AddrW-1:0] paddr,
  input  logic [sle_pkg::DataW-1:0] pwdata,
  input  logic                      pready,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o,
  output int unsigned               entries_o,
  output int unsigned               results_o,
  output int unsigned               stored_o,
  output int unsigned               stopped_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       accepted;
    logic [2:0] slot;
    logic [4:0] row;
    logic [7:0] x;
    logic [7:0] tile;
    logic       overflow;
    logic       seen;
    logic       stopped;
  } sprite_result_t;

  sle_pkg::cfg_t                 cfg;
  logic [sle_pkg::HitW-1:0]      hit_cnt;
  logic [sle_pkg::EntryW-1:0]    entry_cnt;
  logic                          scan_done;
  logic                          ovf_flag;
  logic                          seen_flag;
  sprite_result_t                sprite_results_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    entries_o    = 0;
    results_o    = 0;
    stored_o     = 0;
    stopped_o    = 0;
  end

  // evaluates one attribute entry against the current line scan
  function automatic sprite_result_t evaluate_entry(input logic start,
      input logic [7:0] line, input logic [7:0] y, input logic [7:0] x,
      input logic [7:0] tile);
    sprite_result_t res;
    logic [5:0]     height;
    logic [7:0]     row;
    res = '0;
    if (start) begin
      hit_cnt   = '0;
      entry_cnt = '0;
      scan_done = 1'b0;
    end
    if (!scan_done && entry_cnt < sle_pkg::TableEntries) begin
      entry_cnt++;
      if (!cfg.extended_mode && y == sle_pkg::EndMarkY) begin
        scan_done = 1'b1;
      end else begin
        height = 6'd8 << cfg.tall_sprites << cfg.zoom_sprites;
        row    = line - (y | {7'd0, cfg.zoom_sprites});
        if (row < height) begin
          seen_flag = 1'b1;
          if (hit_cnt >= sle_pkg::SlotsPerLine) begin
            if (line < cfg.active_lines) ovf_flag = 1'b1;
            if (cfg.limit_enable) scan_done = 1'b1;
          end else begin
            res.accepted = 1'b1;
            res.slot     = hit_cnt[2:0];
            res.row      = row[4:0];
            res.x        = x;
            res.tile     = tile;
            hit_cnt++;
          end
        end
      end
    end
    res.overflow = ovf_flag;
    res.seen     = seen_flag;
    res.stopped  = scan_done;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sprite_result_t want;
    if (!rst_ni) begin
      cfg.tall_sprites  = 1'b0;
      cfg.zoom_sprites  = 1'b0;
      cfg.extended_mode = 1'b0;
      cfg.limit_enable  = 1'b1;
      cfg.active_lines  = sle_pkg::ActiveLinesRst;
      hit_cnt   = '0;
      entry_cnt = '0;
      scan_done = 1'b0;
      ovf_flag  = 1'b0;
      seen_flag = 1'b0;
      sprite_results_q.delete();
      pending_o = 0;
    end else begin
      // a result leaving now always belongs to an earlier entry
      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        if (sprite_results_q.size() == 0) begin
          $error("result transaction with no entry waiting for it");
          fail_count_o++;
        end else begin
          want = sprite_results_q.pop_front();
          check_field("accepted", want.accepted, m_axis_tuser);
          check_field("slot", want.slot, m_axis_tdata[2:0]);
          check_field("row_in_sprite", want.row, m_axis_tdata[7:3]);
          check_field("out_x", want.x, m_axis_tdata[15:8]);
          check_field("out_tile", want.tile, m_axis_tdata[23:16]);
          check_field("overflow_flag", want.overflow, m_axis_tdata[24]);
          check_field("sprite_seen", want.seen, m_axis_tdata[25]);
          check_field("scan_stopped", want.stopped, m_axis_tdata[26]);
          check_field("tdata padding", 0, m_axis_tdata[31:27]);
          if (want.accepted) stored_o++;
          if (want.stopped) stopped_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        entries_o++;
        sprite_results_q.push_back(evaluate_entry(s_axis_tuser, s_axis_tdata[7:0],
            s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]));
      end
      if (psel && penable && pwrite && pready) begin
        case (sle_pkg::reg_idx_e'(paddr[sle_pkg::AddrW-1:2]))
          sle_pkg::REG_TALL:   cfg.tall_sprites  = pwdata[0];
          sle_pkg::REG_ZOOM:   cfg.zoom_sprites  = pwdata[0];
          sle_pkg::REG_EXT:    cfg.extended_mode = pwdata[0];
          sle_pkg::REG_LIMIT:  cfg.limit_enable  = pwdata[0];
          sle_pkg::REG_ACTIVE: cfg.active_lines  = pwdata[7:0];
          default: ;
        endcase
      end
      pending_o = sprite_results_q.size();
    end
  end

endmodule

/* tb/tb_sprite_line_evaluator.sv */
// ----------------------------------------------------------------------------
// tb_sprite_line_evaluator
// Drives attribute entries and register writes into the sprite line
// evaluator under varying back-pressure; the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sprite_line_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PhaseEntries = 230;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [31:0]               s_axis_tdata = '0;   // line_number, entry_y, entry_x, entry_tile
  logic                      s_axis_tuser = 1'b0; // line_start
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  // slot, row_in_sprite, out_x, out_tile, overflow_flag, sprite_seen, scan_stopped, zeros
  logic [31:0]               m_axis_tdata;
  logic                      m_axis_tuser;        // accepted
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [sle_pkg::AddrW-1:0] paddr = '0;
  logic [sle_pkg::DataW-1:0] pwdata = '0;
  logic [sle_pkg::DataW-1:0] prdata;
  logic                      pready;

  int unsigned fail_count, pending, entries, results, stored, stopped;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned random_entries = 0;
  int unsigned cfg_sets = 0;
  logic        cur_tall = 1'b0;
  logic        cur_zoom = 1'b0;

  always #1 clk_i = ~clk_i;

  sprite_line_evaluator DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sle_scan_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending), .entries_o(entries),
    .results_o(results), .stored_o(stored), .stopped_o(stopped)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $error("cycle limit reached with %0d results outstanding", pending);
      $display("FAIL");
      $finish;
    end
  end

  // called and returns at a falling edge; tvalid stays up for the caller
  task automatic push_entry(input logic start, input logic [7:0] line,
      input logic [7:0] y, input logic [7:0] x, input logic [7:0] tile);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= start;
    s_axis_tdata  <= {tile, x, y, line};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // psel stays high between back-to-back writes, the caller drops it
  task automatic write_reg(input sle_pkg::reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic tall, input logic zoom, input logic ext,
      input logic limit, input logic [7:0] active);
    write_reg(sle_pkg::REG_TALL, {31'd0, tall});
    write_reg(sle_pkg::REG_ZOOM, {31'd0, zoom});
    write_reg(sle_pkg::REG_EXT, {31'd0, ext});
    write_reg(sle_pkg::REG_LIMIT, {31'd0, limit});
    write_reg(sle_pkg::REG_ACTIVE, {24'd0, active});
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    cur_tall = tall;
    cur_zoom = zoom;
    cfg_sets++;
    @(negedge clk_i);
  endtask

  task automatic random_config();
    logic [7:0] active;
    case ($urandom_range(3))
      0:       active = 8'd0;
      1:       active = 8'd255;
      2:       active = sle_pkg::ActiveLinesRst;
      default: active = 8'($urandom_range(255));
    endcase
    set_config(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
               1'($urandom_range(1)), active);
  endtask

  // one scanline: mostly entries near the sprite window, a few terminators
  task automatic scan_line();
    logic [7:0]  line;
    logic [7:0]  y;
    int unsigned len;
    int unsigned height;
    int unsigned r;
    line   = 8'($urandom_range(255));
    height = 8 << cur_tall << cur_zoom;
    len    = ($urandom_range(9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 20);
    for (int unsigned k = 0; k < len; k++) begin
      r = $urandom_range(99);
      if (r < 55) y = line - 8'($urandom_range(0, height + 1));
      else if (r < 60) y = sle_pkg::EndMarkY;
      else y = 8'($urandom_range(255));
      // the odd line continues the previous scan without a start marker
      push_entry((k == 0) && ($urandom_range(19) != 0), line, y,
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      random_entries++;
    end
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 17;
    rx_idle_pct = 78;

    // reset settings: entry before any line start, field extremes, list end
    push_entry(1'b0, 8'd20, 8'd20, 8'h00, 8'h00);
    push_entry(1'b1, 8'd255, 8'd255, 8'hff, 8'hff);
    push_entry(1'b0, 8'd255, 8'd248, 8'h01, 8'h02);
    push_entry(1'b0, 8'd255, 8'd247, 8'h03, 8'h04);
    push_entry(1'b0, 8'd255, 8'd0, 8'h05, 8'h06);
    push_entry(1'b0, 8'd255, sle_pkg::EndMarkY, 8'h07, 8'h08);
    push_entry(1'b0, 8'd255, 8'd255, 8'h09, 8'h0a);
    // nine hits on a visible line: overflow and the eight-sprite stop
    for (int i = 0; i < 9; i++) begin
      push_entry(i == 0, 8'd100, 8'(100 - (i % 8)), 8'(16 * i), 8'(i + 1));
    end
    push_entry(1'b0, 8'd100, 8'd100, 8'h55, 8'haa);
    drain();

    // tall and zoomed, terminator off, no limit, no visible lines
    set_config(1'b1, 1'b1, 1'b1, 1'b0, 8'd0);
    push_entry(1'b1, 8'd220, sle_pkg::EndMarkY, 8'h11, 8'h22);
    push_entry(1'b0, 8'd220, 8'd189, 8'h33, 8'h44);
    push_entry(1'b0, 8'd220, 8'd187, 8'h55, 8'h66);
    for (int i = 0; i < 7; i++) begin
      push_entry(1'b0, 8'd220, 8'd200, 8'(i), 8'(255 - i));
    end
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 17;
          rx_idle_pct = 78;
        end
        1: begin
          tx_idle_pct = 78;
          rx_idle_pct = 17;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (random_entries < (ph + 1) * PhaseEntries) begin
        drain();
        random_config();
        repeat ($urandom_range(3, 8)) scan_line();
      end
    end
    drain();

    $display("%0d entries sent, %0d results checked, %0d sprites stored, %0d stopped",
             entries, results, stored, stopped);
    $display("%0d register settings used across three back-pressure phases", cfg_sets);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
